>>> rtl/ext2dbl_pkg.sv
package ext2dbl_pkg;

	localparam int unsigned EXT_EXP_W = 15;
	localparam int unsigned EXT_SIG_W = 64;
	localparam int unsigned DBL_W     = 64;
	localparam int unsigned DBL_EXP_W = 11;
	localparam int unsigned DBL_FRC_W = 52;
	localparam int unsigned SHIFT_W   = 7;

	typedef struct packed {
		logic                 sign;
		logic [EXT_EXP_W-1:0] biased_exponent;
		logic [EXT_SIG_W-1:0] significand;
	} ext_word_t;

	localparam logic [EXT_EXP_W-1:0] EXT_EXP_ALL_ONES = 15'h7FFF;
	// rebias 16383 -> 1023: double exponent e = bexp - REBIAS
	localparam logic [EXT_EXP_W-1:0] REBIAS           = 15'd15360;
	// bexp at which e reaches the double all-ones exponent
	localparam logic [EXT_EXP_W-1:0] EXP_OVERFLOW     = 15'd17407;
	// smallest bexp with e >= 1
	localparam logic [EXT_EXP_W-1:0] EXP_NORMAL_MIN   = 15'd15361;
	// smallest bexp with e >= -52
	localparam logic [EXT_EXP_W-1:0] EXP_SUB_MIN      = 15'd15308;
	// subnormal shift is 12 - e = SUB_SHIFT_BASE - bexp
	localparam logic [EXT_EXP_W-1:0] SUB_SHIFT_BASE   = 15'd15372;
	localparam logic [SHIFT_W-1:0]   NORMAL_SHIFT     = 7'd11;

	localparam logic [DBL_W-1:0] DBL_SIGN_BIT    = 64'h8000_0000_0000_0000;
	localparam logic [DBL_W-1:0] DBL_INF         = 64'h7FF0_0000_0000_0000;
	localparam logic [DBL_W-1:0] DBL_QNAN_SIGNED = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DBL_W-1:0] DBL_SNAN_SIGNED = 64'h7FF7_FFFF_FFFF_FFFF;
	localparam logic [DBL_W-1:0] DBL_ODD_QNAN    = 64'hFFF8_0000_0000_0000;

	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_INF,
		CLS_PSEUDO_INF,
		CLS_QNAN,
		CLS_SNAN,
		CLS_UNNORMAL,
		CLS_FINITE
	} ext_class_t;

endpackage

>>> rtl/extended_to_double_convert.sv
// Converts x87 80-bit extended values to IEEE binary64 bit patterns.
//
// Input channel: in_valid / in_stall with the fields sign, biased_exponent
// and significand. A word is taken at a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with double_bits,
// taken the same way.
//
// The word is captured in an input register, goes through one pass of
// classify, shift, round and rebias logic, and lands in the result
// register. One word is accepted every cycle, so throughput is one word
// per clock as long as the receiver keeps out_stall low.
//
// While out_stall is high the result holds; the input register still takes
// one more word, and only then does in_stall rise. in_stall is a function
// of out_stall and the register occupancy in the same cycle.
//
// Reset (arst_n low, asynchronous) empties both registers; no state
// survives between words.
module extended_to_double_convert
	import ext2dbl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 sign,
	input  logic [EXT_EXP_W-1:0] biased_exponent,
	input  logic [EXT_SIG_W-1:0] significand,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DBL_W-1:0]     double_bits
);

	ext_word_t        word_s1;
	logic             valid_s1;
	logic [DBL_W-1:0] result_s2;
	logic             valid_s2;
	logic [DBL_W-1:0] result_c;
	logic             adv_s2;
	logic             load_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= '{sign: sign, biased_exponent: biased_exponent,
				significand: significand};
		end
	end

	ext2dbl_core u_core (
		.word        (word_s1),
		.double_bits (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid   = valid_s2;
	assign double_bits = result_s2;

	// stall back only when both registers are full and the receiver holds
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall raised without a full pipeline");

	// a converted word advances to the output unless the output is held
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(valid_s2 && out_stall)) |=> out_valid)
		else $error("converted word lost between stages");

	// drain: a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated after being taken");

endmodule

>>> rtl/ext2dbl_round.sv
module ext2dbl_round
	import ext2dbl_pkg::*;
(
	input  logic [EXT_SIG_W-1:0] value,
	input  logic [SHIFT_W-1:0]   shift,
	output logic [EXT_SIG_W-1:0] rounded
);

	logic [EXT_SIG_W-1:0] quot;
	logic [EXT_SIG_W-1:0] sticky_mask;
	logic [SHIFT_W-1:0]   rpos;
	logic                 rbit;
	logic                 sticky;

	// used shifts lie in 11..64, so the round bit index fits in six bits
	always_comb begin
		rpos        = shift - SHIFT_W'(1);
		quot        = value >> shift;
		rbit        = value[rpos[5:0]];
		sticky_mask = (EXT_SIG_W'(1) << rpos[5:0]) - EXT_SIG_W'(1);
		sticky      = |(value & sticky_mask);
		rounded     = quot + EXT_SIG_W'(rbit & (sticky | quot[0]));
	end

endmodule

>>> rtl/ext2dbl_core.sv
module ext2dbl_core
	import ext2dbl_pkg::*;
(
	input  ext_word_t        word,
	output logic [DBL_W-1:0] double_bits
);

	ext_class_t           cls;
	logic                 is_normal;
	logic                 overflow;
	logic                 too_small;
	logic [SHIFT_W-1:0]   shift;
	logic [EXT_EXP_W-1:0] sub_shift;
	logic [EXT_EXP_W-1:0] exp_field;
	logic [DBL_W-1:0]     exp_base;
	logic [EXT_SIG_W-1:0] rounded;
	logic [DBL_W-1:0]     sgn;

	always_comb begin
		priority if (word.biased_exponent == '0) begin
			cls = CLS_ZERO;
		end else if (word.biased_exponent == EXT_EXP_ALL_ONES) begin
			priority if (word.significand[62:0] == '0) begin
				cls = word.significand[63] ? CLS_INF : CLS_PSEUDO_INF;
			end else if (word.significand[62]) begin
				cls = CLS_QNAN;
			end else begin
				cls = CLS_SNAN;
			end
		end else if (!word.significand[63]) begin
			cls = CLS_UNNORMAL;
		end else begin
			cls = CLS_FINITE;
		end
	end

	assign overflow  = word.biased_exponent >= EXP_OVERFLOW;
	assign is_normal = word.biased_exponent >= EXP_NORMAL_MIN;
	assign too_small = word.biased_exponent < EXP_SUB_MIN;
	assign sub_shift = SUB_SHIFT_BASE - word.biased_exponent;
	assign exp_field = word.biased_exponent - EXP_NORMAL_MIN;
	assign shift     = is_normal ? NORMAL_SHIFT : sub_shift[SHIFT_W-1:0];
	// a rounding carry out of the mantissa steps the exponent up
	assign exp_base  = is_normal ? {1'b0, exp_field[DBL_EXP_W-1:0], {DBL_FRC_W{1'b0}}} : '0;
	assign sgn       = word.sign ? DBL_SIGN_BIT : '0;

	ext2dbl_round u_round (
		.value   (word.significand),
		.shift   (shift),
		.rounded (rounded)
	);

	always_comb begin
		unique case (cls)
			CLS_ZERO:       double_bits = sgn;
			CLS_INF:        double_bits = sgn | DBL_INF;
			CLS_PSEUDO_INF: double_bits = DBL_ODD_QNAN;
			CLS_QNAN:       double_bits = sgn | DBL_QNAN_SIGNED;
			CLS_SNAN:       double_bits = sgn | DBL_SNAN_SIGNED;
			CLS_UNNORMAL:   double_bits = DBL_ODD_QNAN;
			CLS_FINITE: begin
				priority if (overflow) begin
					double_bits = sgn | DBL_INF;
				end else if (too_small) begin
					double_bits = sgn;
				end else begin
					double_bits = sgn | (exp_base + rounded);
				end
			end
			default:        double_bits = DBL_ODD_QNAN;
		endcase
	end

endmodule
